[sv/spq_pkg.sv]
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] in_priority;
    logic signed [31:0] in_data;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] out_priority;
    logic signed [31:0] out_data;
    logic [4:0]         entry_count;
    logic               is_empty;
  } out_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic signed [31:0] data;
  } entry_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_ent;
  } ctl_t;

endpackage

[sv/spq_cell.sv]
module spq_cell (
  input  logic           clk,
  input  spq_pkg::ctl_t  ctl,
  input  logic           occ,
  input  logic           left_stay,
  input  spq_pkg::entry_t left_ent,
  input  spq_pkg::entry_t right_ent,
  output spq_pkg::entry_t ent,
  output logic           stay
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // Equal priorities stay ahead of the newcomer, which keeps them first-in first-out.
  assign stay = occ && (ent_r.prio <= ctl.new_ent.prio);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (stay) begin
        ent_nxt = ent_r;
      end else if (left_stay) begin
        ent_nxt = ctl.new_ent;
      end else begin
        ent_nxt = left_ent;
      end
    end else if (ctl.rem) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

[sv/sorted_priority_queue_unit.sv]
// Channel  Direction  Handshake                Payload
// in_      input      in_valid / in_ready      spq_pkg::in_t  (kind, priority, data)
// out_     output     out_valid / out_ready    spq_pkg::out_t (status, head, count, empty)
//
// All cells compare against the new priority at once and shift or load in the
// same edge, so a new beat is taken in every cycle while in_ready is high.
// The result sits in one output register; in_ready is low only while that
// register is full and out_ready is low.
// Reset (rst_n, synchronous) clears the count and the output valid; cell
// contents are not cleared and are only read below the count.
module sorted_priority_queue_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  spq_pkg::in_t  in_payload,
  output logic          out_valid,
  input  logic          out_ready,
  output spq_pkg::out_t out_payload
);
  import spq_pkg::*;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  out_t               out_r;
  out_t               out_nxt;
  logic               fire;
  logic               full;
  logic               empty;
  ctl_t               ctl;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] stay;
  entry_t             ents [CAPACITY];
  logic [CNT_W+4:0]   count_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  assign ctl.ins          = fire && (in_payload.kind == KIND_INSERT) && !full;
  assign ctl.rem          = fire && (in_payload.kind == KIND_REMOVE) && !empty;
  assign ctl.new_ent.prio = in_payload.in_priority;
  assign ctl.new_ent.data = in_payload.in_data;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign occ[g] = (count_r > CNT_W'(g));
      if (g == 0) begin : g_head
        spq_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (occ[g]),
          .left_stay (1'b1),
          .left_ent  (ctl.new_ent),
          .right_ent (ents[g+1]),
          .ent       (ents[g]),
          .stay      (stay[g])
        );
      end else if (g == CAPACITY - 1) begin : g_tail
        spq_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (occ[g]),
          .left_stay (stay[g-1]),
          .left_ent  (ents[g-1]),
          .right_ent (ents[g]),
          .ent       (ents[g]),
          .stay      (stay[g])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk       (clk),
          .ctl       (ctl),
          .occ       (occ[g]),
          .left_stay (stay[g-1]),
          .left_ent  (ents[g-1]),
          .right_ent (ents[g+1]),
          .ent       (ents[g]),
          .stay      (stay[g])
        );
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_ext = (CNT_W + 5)'(count_nxt);

  always_comb begin
    out_nxt              = '0;
    out_nxt.status       = ST_DONE;
    out_nxt.entry_count  = count_ext[4:0];
    out_nxt.is_empty     = (count_nxt == '0);
    unique case (in_payload.kind)
      KIND_INSERT: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.out_priority = ents[0].prio;
          out_nxt.out_data     = ents[0].data;
        end
      end
      default: out_nxt.status = ST_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result until it is taken.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("accepted insert did not grow the count");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    occ[1] |-> ents[0].prio <= ents[1].prio)
    else $error("head cell out of order");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_empty |-> out_r.entry_count == 5'd0)
    else $error("empty flag with nonzero count");
`endif

endmodule
